// ===== hdl/fsrq_pkg.sv =====
// Package for the flash sector ring queue controller.
// Holds geometry constants, field widths, operation and mode codes, and shared types.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package fsrq_pkg;

  // Ring geometry. Sector and record sizes are powers of two.
  localparam int SECTOR_COUNT       = 16;
  localparam int SECTOR_BYTES       = 4096;
  localparam int RECORD_BYTES       = 32;
  localparam int RECORDS_PER_SECTOR = 128;
  localparam int CAPACITY           = SECTOR_COUNT * RECORDS_PER_SECTOR;

  // Internal pointer widths.
  localparam int SECT_W   = $clog2(SECTOR_COUNT);
  localparam int OFFS_W   = $clog2(SECTOR_BYTES + 1);
  localparam int RB_SHIFT = $clog2(RECORD_BYTES);

  // Field widths.
  localparam int ADDR_W    = 24;
  localparam int MODE_W    = 2;
  localparam int RSECT_W   = 8;
  localparam int ROFFS_W   = 16;
  localparam int OP_W      = 3;
  localparam int CNT_W     = 12;
  localparam int TOT_W     = CNT_W + 2;
  localparam int CFG_IDX_W = 1;

  // Result slots of one request.
  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W    = 2;

  typedef logic [SECT_W-1:0]  sect_t;
  typedef logic [OFFS_W-1:0]  offs_t;
  typedef logic [OFFS_W:0]    offx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLOT_W-1:0]  slot_idx_t;

  localparam offx_t RB_X = offx_t'(RECORD_BYTES);
  localparam offx_t SB_X = offx_t'(SECTOR_BYTES);

  // Limits used to range check restored pointers.
  localparam logic [RSECT_W:0] RSECT_LIM = (RSECT_W + 1)'(SECTOR_COUNT);
  localparam logic [ROFFS_W:0] ROFFS_LIM = (ROFFS_W + 1)'(SECTOR_BYTES);

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_AREA_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_ADDR = 1'b1;
  localparam addr_t AREA_BASE_RESET  = addr_t'(4096);
  localparam addr_t INDEX_ADDR_RESET = addr_t'(0);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_RESTORE = 2'd3
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_NONE    = 3'd0,
    OP_ERASE   = 3'd1,
    OP_PROGRAM = 3'd2,
    OP_READ    = 3'd3,
    OP_SAVE    = 3'd4
  } op_t;

  // One pending flash operation: code plus the ring location it targets.
  typedef struct packed {
    op_t   op;
    sect_t sector;
    offs_t offset;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      start;
    logic      load;
    slot_idx_t slot;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_last;
  } dp_status_t;

  // Advance a sector pointer around the ring.
  function automatic sect_t next_sector(input sect_t s);
    if (s == sect_t'(SECTOR_COUNT - 1)) begin
      return '0;
    end
    return s + sect_t'(1);
  endfunction

endpackage

// ===== hdl/fsrq_if.sv =====
// Handshake interfaces for the request and result channels of the queue controller.
// Depends on fsrq_pkg for the field widths.
`timescale 1ns / 1ps

interface fsrq_req_if;
  logic                             valid;
  logic                             ready;
  logic [fsrq_pkg::MODE_W-1:0]      mode;
  logic [fsrq_pkg::RSECT_W-1:0]     restored_write_sector;
  logic [fsrq_pkg::ROFFS_W-1:0]     restored_write_offset;
  logic [fsrq_pkg::RSECT_W-1:0]     restored_read_sector;
  logic [fsrq_pkg::ROFFS_W-1:0]     restored_read_offset;

  modport source (
    output valid, mode, restored_write_sector, restored_write_offset,
           restored_read_sector, restored_read_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, restored_write_sector, restored_write_offset,
           restored_read_sector, restored_read_offset,
    output ready
  );
endinterface

interface fsrq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fsrq_pkg::OP_W-1:0]    operation;
  logic [fsrq_pkg::ADDR_W-1:0]  flash_address;
  logic                         status;
  logic [fsrq_pkg::CNT_W-1:0]   record_count;
  logic                         last;

  modport source (
    output valid, operation, flash_address, status, record_count, last,
    input  ready
  );
  modport sink (
    input  valid, operation, flash_address, status, record_count, last,
    output ready
  );
endinterface

// ===== hdl/flash_sector_ring_queue_control.sv =====
// Top level of the flash sector ring queue controller.
// Depends on fsrq_pkg, fsrq_if, fsrq_ctrl and fsrq_dp.
`timescale 1ns / 1ps

// Usage:
// A request (push, pop, clear or restore) is a transfer on the req channel.
// Each request yields one to three results on the rsp channel, each naming a
// flash operation and its byte address, in the order the flash must see them.
// Every result carries the record count after the request; the final one has
// last set. The cfg port sets the ring base address and the pointer index
// address; write it only while no request is in flight.
// Sequence: the accepting cycle updates the pointers, a settle state lets the
// registered record count follow, a load state fills the result register,
// then one result leaves per cycle while the receiver is ready. The next
// request is taken in the cycle after the last result transfer.
// When the receiver stalls, the result register holds its value and the
// block waits. Reset empties the queue, restores the register defaults and
// leaves the block ready for a request in the next cycle.

module flash_sector_ring_queue_control (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fsrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsrq_pkg::ADDR_W-1:0]     cfg_wr_data,
  fsrq_req_if.sink                        req,
  fsrq_rsp_if.source                      rsp
);
  import fsrq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  fsrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // Pointer and address datapath.
  fsrq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .req_mode         (req.mode),
    .req_write_sector (req.restored_write_sector),
    .req_write_offset (req.restored_write_offset),
    .req_read_sector  (req.restored_read_sector),
    .req_read_offset  (req.restored_read_offset),
    .cmd              (cmd),
    .status           (status),
    .out_operation    (rsp.operation),
    .out_address      (rsp.flash_address),
    .out_status       (rsp.status),
    .out_count        (rsp.record_count),
    .out_last         (rsp.last)
  );

endmodule

// ===== hdl/fsrq_ctrl.sv =====
// Sequencing controller of the queue block: request acceptance and result emission.
// Depends on fsrq_pkg for the command and status structs.
`timescale 1ns / 1ps

module fsrq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 rsp_ready,
  input  fsrq_pkg::dp_status_t status,
  output logic                 in_ready,
  output logic                 out_valid,
  output fsrq_pkg::dp_cmd_t    cmd
);
  import fsrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETTLE,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t    state;
  slot_idx_t idx;

  // Commands to the datapath.
  always_comb begin
    cmd.start = in_ready && req_valid;
    cmd.load  = (state == S_LOAD) || ((state == S_EMIT) && rsp_ready && !status.out_last);
    cmd.slot  = (state == S_LOAD) ? '0 : idx + slot_idx_t'(1);
  end

  // State, slot counter and handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state    <= S_SETTLE;
            in_ready <= 1'b0;
          end
        end
        S_SETTLE: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state     <= S_EMIT;
          idx       <= '0;
          out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (rsp_ready) begin
            if (status.out_last) begin
              state     <= S_IDLE;
              out_valid <= 1'b0;
              in_ready  <= 1'b1;
            end else begin
              idx <= idx + slot_idx_t'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/fsrq_dp.sv =====
// Datapath of the queue block: pointers, configuration, record count and result register.
// Depends on fsrq_pkg for constants, codes and types.
`timescale 1ns / 1ps

module fsrq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fsrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsrq_pkg::ADDR_W-1:0]       cfg_wr_data,
  input  logic [fsrq_pkg::MODE_W-1:0]       req_mode,
  input  logic [fsrq_pkg::RSECT_W-1:0]      req_write_sector,
  input  logic [fsrq_pkg::ROFFS_W-1:0]      req_write_offset,
  input  logic [fsrq_pkg::RSECT_W-1:0]      req_read_sector,
  input  logic [fsrq_pkg::ROFFS_W-1:0]      req_read_offset,
  input  fsrq_pkg::dp_cmd_t                 cmd,
  output fsrq_pkg::dp_status_t              status,
  output logic [fsrq_pkg::OP_W-1:0]         out_operation,
  output logic [fsrq_pkg::ADDR_W-1:0]       out_address,
  output logic                              out_status,
  output logic [fsrq_pkg::CNT_W-1:0]        out_count,
  output logic                              out_last
);
  import fsrq_pkg::*;

  // Architectural state and configuration.
  sect_t wsec, rsec;
  offs_t woff, roff;
  addr_t base_addr, index_addr;
  cnt_t  cnt;

  // Per-request result slots.
  slot_t     slots [NUM_SLOTS];
  slot_idx_t last_slot;
  logic      empty_flag;

  // Next-state values computed at acceptance.
  sect_t     wsec_next, rsec_next;
  offs_t     woff_next, roff_next;
  slot_t     slots_next [NUM_SLOTS];
  slot_idx_t last_slot_next;
  logic      empty_next;

  // Record count of the current pointers.
  sect_t                 sdiff;
  cnt_t                  sect_part;
  offx_t                 odiff;
  offs_t                 omag;
  offs_t                 oquot;
  logic [TOT_W-1:0]      total;
  cnt_t                  cnt_next;

  always_comb begin
    if (wsec >= rsec) begin
      sdiff = wsec - rsec;
    end else begin
      sdiff = sect_t'({1'b0, wsec} + (SECT_W + 1)'(SECTOR_COUNT) - {1'b0, rsec});
    end
    sect_part = cnt_t'(sdiff) * cnt_t'(RECORDS_PER_SECTOR);
    odiff     = {1'b0, woff} - {1'b0, roff};
    omag      = odiff[OFFS_W] ? offs_t'(-odiff) : offs_t'(odiff);
    // Division truncates toward zero, so divide the magnitude and restore the sign.
    oquot     = omag >> RB_SHIFT;
    total     = TOT_W'(sect_part) +
                (odiff[OFFS_W] ? (~TOT_W'(oquot) + TOT_W'(1)) : TOT_W'(oquot));
    if (total[TOT_W-1]) begin
      cnt_next = '0;
    end else if (total > TOT_W'(CAPACITY)) begin
      cnt_next = cnt_t'(CAPACITY);
    end else begin
      cnt_next = cnt_t'(total);
    end
  end

  // Request decode: new pointers and the list of flash operations.
  sect_t ws1, rs1;
  offs_t wo1;
  offx_t ro1;
  logic  restore_bad;

  always_comb begin
    wsec_next      = wsec;
    woff_next      = woff;
    rsec_next      = rsec;
    roff_next      = roff;
    last_slot_next = '0;
    empty_next     = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slots_next[i] = '{op: OP_NONE, sector: '0, offset: '0};
    end
    ws1         = wsec;
    wo1         = woff;
    rs1         = rsec;
    ro1         = {1'b0, roff};
    restore_bad = 1'b0;

    unique case (mode_t'(req_mode))
      MODE_PUSH: begin
        if ({1'b0, woff} + RB_X > SB_X) begin
          // Record does not fit: move to the next sector and erase it first.
          ws1           = next_sector(wsec);
          wo1           = '0;
          slots_next[0] = '{op: OP_ERASE, sector: ws1, offset: '0};
          if (ws1 == rsec) begin
            rsec_next = next_sector(ws1);
            roff_next = '0;
          end
          slots_next[1]  = '{op: OP_PROGRAM, sector: ws1, offset: wo1};
          slots_next[2]  = '{op: OP_SAVE, sector: '0, offset: '0};
          last_slot_next = slot_idx_t'(2);
        end else begin
          slots_next[0]  = '{op: OP_PROGRAM, sector: ws1, offset: wo1};
          slots_next[1]  = '{op: OP_SAVE, sector: '0, offset: '0};
          last_slot_next = slot_idx_t'(1);
        end
        wsec_next = ws1;
        woff_next = wo1 + offs_t'(RECORD_BYTES);
      end
      MODE_POP: begin
        if (cnt == '0) begin
          empty_next = 1'b1;
        end else begin
          slots_next[0] = '{op: OP_READ, sector: rsec, offset: roff};
          ro1 = {1'b0, roff} + RB_X;
          if (ro1 + RB_X > SB_X) begin
            rs1 = next_sector(rsec);
            ro1 = '0;
          end
          if ((rs1 == wsec) && (ro1 >= {1'b0, woff})) begin
            // Reader caught the writer: start over at sector zero.
            wsec_next      = '0;
            woff_next      = '0;
            rsec_next      = '0;
            roff_next      = '0;
            slots_next[1]  = '{op: OP_ERASE, sector: '0, offset: '0};
            slots_next[2]  = '{op: OP_SAVE, sector: '0, offset: '0};
            last_slot_next = slot_idx_t'(2);
          end else begin
            rsec_next      = rs1;
            roff_next      = offs_t'(ro1);
            slots_next[1]  = '{op: OP_SAVE, sector: '0, offset: '0};
            last_slot_next = slot_idx_t'(1);
          end
        end
      end
      MODE_CLEAR: begin
        wsec_next      = '0;
        woff_next      = '0;
        rsec_next      = '0;
        roff_next      = '0;
        slots_next[0]  = '{op: OP_ERASE, sector: '0, offset: '0};
        slots_next[1]  = '{op: OP_SAVE, sector: '0, offset: '0};
        last_slot_next = slot_idx_t'(1);
      end
      MODE_RESTORE: begin
        restore_bad = ({1'b0, req_write_sector} >= RSECT_LIM) ||
                      ({1'b0, req_read_sector} >= RSECT_LIM) ||
                      ({1'b0, req_write_offset} >= ROFFS_LIM) ||
                      ({1'b0, req_read_offset} >= ROFFS_LIM);
        if (restore_bad) begin
          wsec_next     = '0;
          woff_next     = '0;
          rsec_next     = '0;
          roff_next     = '0;
          slots_next[0] = '{op: OP_SAVE, sector: '0, offset: '0};
        end else begin
          wsec_next = sect_t'(req_write_sector);
          woff_next = offs_t'(req_write_offset);
          rsec_next = sect_t'(req_read_sector);
          roff_next = offs_t'(req_read_offset);
        end
      end
      default: begin
        empty_next = 1'b0;
      end
    endcase
  end

  // Pointers, configuration and the running record count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wsec       <= '0;
      woff       <= '0;
      rsec       <= '0;
      roff       <= '0;
      base_addr  <= AREA_BASE_RESET;
      index_addr <= INDEX_ADDR_RESET;
      cnt        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_AREA_BASE:  base_addr  <= cfg_wr_data;
          REG_INDEX_ADDR: index_addr <= cfg_wr_data;
          default:        base_addr  <= base_addr;
        endcase
      end
      if (cmd.start) begin
        wsec <= wsec_next;
        woff <= woff_next;
        rsec <= rsec_next;
        roff <= roff_next;
      end
      cnt <= cnt_next;
    end
  end

  // Slot list of the request in progress.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots[i] <= slots_next[i];
      end
      last_slot  <= last_slot_next;
      empty_flag <= empty_next;
    end
  end

  // Address of the selected slot.
  slot_t sel;
  addr_t sel_addr;

  always_comb begin
    sel = slots[cmd.slot];
    case (sel.op) inside
      OP_ERASE, OP_PROGRAM, OP_READ: begin
        sel_addr = base_addr + addr_t'(sel.sector) * addr_t'(SECTOR_BYTES) +
                   addr_t'(sel.offset);
      end
      OP_SAVE: sel_addr = index_addr;
      default: sel_addr = '0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_operation <= sel.op;
      out_address   <= sel_addr;
      out_status    <= empty_flag;
      out_count     <= cnt;
      out_last      <= (cmd.slot == last_slot);
    end
  end

  assign status.out_last = out_last;

endmodule

// ===== hdl/fsrq_checker.sv =====
// Port-level checks of the queue controller, bound to the top level.
// Depends on fsrq_pkg for codes and the capacity constant.
`timescale 1ns / 1ps

module fsrq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [fsrq_pkg::OP_W-1:0]      rsp_operation,
  input logic [fsrq_pkg::ADDR_W-1:0]    rsp_flash_address,
  input logic                           rsp_status,
  input logic [fsrq_pkg::CNT_W-1:0]     rsp_record_count,
  input logic                           rsp_last
);
  import fsrq_pkg::*;

  // No new request is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request ready while a result is pending");

  // The first result of a request appears after the settle and load states that follow its transfer.
  a_first_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##3 rsp_valid)
    else $error("first result not presented on time");

  // The record count never exceeds the ring capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_record_count <= cnt_t'(CAPACITY)))
    else $error("record count above capacity");

  // An empty report is a lone result with no flash operation.
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status) |-> ((rsp_operation == OP_NONE) && rsp_last))
    else $error("malformed empty report");

  // A stalled result holds its address.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_flash_address)))
    else $error("stalled result changed");

endmodule

bind flash_sector_ring_queue_control fsrq_checker u_fsrq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_operation     (rsp.operation),
  .rsp_flash_address (rsp.flash_address),
  .rsp_status        (rsp.status),
  .rsp_record_count  (rsp.record_count),
  .rsp_last          (rsp.last)
);

// ===== tb/flash_sector_ring_queue_control_tb.sv =====
// Self-checking testbench for the flash sector ring queue controller.
// Drives requests, predicts every flash operation, checks each result transfer.
// Depends on fsrq_pkg, fsrq_if and flash_sector_ring_queue_control.
`timescale 1ns / 1ps

module flash_sector_ring_queue_control_tb;
  import fsrq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    mode_t               mode;
    logic [RSECT_W-1:0]  wsec;
    logic [ROFFS_W-1:0]  woff;
    logic [RSECT_W-1:0]  rsec;
    logic [ROFFS_W-1:0]  roff;
    bit                  wait_drain;
  } request_t;

  typedef struct {
    op_t   op;
    addr_t addr;
    logic  status;
    cnt_t  count;
    logic  last;
  } flash_op_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  addr_t                cfg_wr_data;

  fsrq_req_if req ();
  fsrq_rsp_if rsp ();

  flash_sector_ring_queue_control uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // Requests waiting to be sent and flash operations still owed by the block.
  request_t  requests_to_send[$];
  flash_op_t flash_ops_due[$];

  // Our own copy of the ring pointers and the two address registers.
  sect_t ring_wsec = '0;
  offs_t ring_woff = '0;
  sect_t ring_rsec = '0;
  offs_t ring_roff = '0;
  addr_t area_base = AREA_BASE_RESET;
  addr_t index_addr = INDEX_ADDR_RESET;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatches         = 0;
  int results_checked    = 0;
  int idle_cycles        = 0;

  // Coverage tallies for the closing summary.
  int n_push, n_pop, n_empty_pop, n_clear, n_restore_ok, n_restore_bad;
  int n_sector_moves, n_overruns, n_caught_up;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic addr_t ring_address(input sect_t s, input offs_t o);
    return addr_t'(32'(area_base) + 32'(s) * SECTOR_BYTES + 32'(o));
  endfunction

  function automatic sect_t ring_next(input sect_t s);
    return sect_t'((int'(s) + 1) % SECTOR_COUNT);
  endfunction

  // Records between the pointers; the offset term is signed and truncates toward zero.
  function automatic cnt_t records_held();
    int sdiff;
    int odiff;
    int total;
    sdiff = int'(ring_wsec) - int'(ring_rsec);
    if (sdiff < 0) begin
      sdiff += SECTOR_COUNT;
    end
    odiff = int'(ring_woff) - int'(ring_roff);
    total = sdiff * RECORDS_PER_SECTOR + odiff / RECORD_BYTES;
    if (total < 0) begin
      total = 0;
    end
    if (total > CAPACITY) begin
      total = CAPACITY;
    end
    return cnt_t'(total);
  endfunction

  function automatic void clear_ring();
    ring_wsec = '0;
    ring_woff = '0;
    ring_rsec = '0;
    ring_roff = '0;
  endfunction

  // Works out the flash operations one request causes and queues them.
  function automatic void plan_flash_ops(input request_t r);
    flash_op_t ops[$];
    cnt_t      held;
    case (r.mode)
      MODE_PUSH: begin
        n_push++;
        if (int'(ring_woff) + RECORD_BYTES > SECTOR_BYTES) begin
          n_sector_moves++;
          ring_wsec = ring_next(ring_wsec);
          ring_woff = '0;
          ops.push_back('{OP_ERASE, ring_address(ring_wsec, '0), 1'b0, '0, 1'b0});
          if (ring_wsec == ring_rsec) begin
            n_overruns++;
            ring_rsec = ring_next(ring_wsec);
            ring_roff = '0;
          end
        end
        ops.push_back('{OP_PROGRAM, ring_address(ring_wsec, ring_woff), 1'b0, '0, 1'b0});
        ring_woff = ring_woff + offs_t'(RECORD_BYTES);
        ops.push_back('{OP_SAVE, index_addr, 1'b0, '0, 1'b0});
      end
      MODE_POP: begin
        if (records_held() == '0) begin
          n_empty_pop++;
          ops.push_back('{OP_NONE, '0, 1'b1, '0, 1'b0});
        end else begin
          n_pop++;
          ops.push_back('{OP_READ, ring_address(ring_rsec, ring_roff), 1'b0, '0, 1'b0});
          ring_roff = ring_roff + offs_t'(RECORD_BYTES);
          if (int'(ring_roff) + RECORD_BYTES > SECTOR_BYTES) begin
            ring_rsec = ring_next(ring_rsec);
            ring_roff = '0;
          end
          if (ring_rsec == ring_wsec && ring_roff >= ring_woff) begin
            n_caught_up++;
            clear_ring();
            ops.push_back('{OP_ERASE, ring_address('0, '0), 1'b0, '0, 1'b0});
          end
          ops.push_back('{OP_SAVE, index_addr, 1'b0, '0, 1'b0});
        end
      end
      MODE_CLEAR: begin
        n_clear++;
        clear_ring();
        ops.push_back('{OP_ERASE, ring_address('0, '0), 1'b0, '0, 1'b0});
        ops.push_back('{OP_SAVE, index_addr, 1'b0, '0, 1'b0});
      end
      default: begin
        if (int'(r.wsec) >= SECTOR_COUNT || int'(r.rsec) >= SECTOR_COUNT ||
            int'(r.woff) >= SECTOR_BYTES || int'(r.roff) >= SECTOR_BYTES) begin
          n_restore_bad++;
          clear_ring();
          ops.push_back('{OP_SAVE, index_addr, 1'b0, '0, 1'b0});
        end else begin
          n_restore_ok++;
          ring_wsec = sect_t'(r.wsec);
          ring_woff = offs_t'(r.woff);
          ring_rsec = sect_t'(r.rsec);
          ring_roff = offs_t'(r.roff);
          ops.push_back('{OP_NONE, '0, 1'b0, '0, 1'b0});
        end
      end
    endcase
    held = records_held();
    foreach (ops[i]) begin
      ops[i].count = held;
      ops[i].last  = (i == ops.size() - 1);
      flash_ops_due.push_back(ops[i]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
    end
  endtask

  // Request driver: holds valid until the transfer, then loads the next item.
  always @(posedge clk) begin : drive_requests
    request_t head;
    bit       go;
    if (rst) begin
      req.valid                 <= 1'b0;
      req.mode                  <= MODE_PUSH;
      req.restored_write_sector <= '0;
      req.restored_write_offset <= '0;
      req.restored_read_sector  <= '0;
      req.restored_read_offset  <= '0;
    end else begin
      if (req.valid && req.ready) begin
        plan_flash_ops(requests_to_send.pop_front());
      end
      if (!(req.valid && !req.ready)) begin
        go = 1'b0;
        if (requests_to_send.size() != 0) begin
          head = requests_to_send[0];
          go = ($urandom_range(99) >= sender_idle_pct) &&
               (!head.wait_drain || flash_ops_due.size() == 0);
        end
        req.valid <= go;
        if (go) begin
          req.mode                  <= head.mode;
          req.restored_write_sector <= head.wsec;
          req.restored_write_offset <= head.woff;
          req.restored_read_sector  <= head.rsec;
          req.restored_read_offset  <= head.roff;
        end
      end
    end
  end

  // Result monitor: random back-pressure, and every transfer checked in order.
  always @(posedge clk) begin : watch_results
    flash_op_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (rsp.valid && rsp.ready) begin
        results_checked++;
        if (flash_ops_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_checked));
        end else begin
          want = flash_ops_due.pop_front();
          check_field("operation", 32'(rsp.operation), 32'(want.op));
          check_field("flash_address", 32'(rsp.flash_address), 32'(want.addr));
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("record_count", 32'(rsp.record_count), 32'(want.count));
          check_field("last", 32'(rsp.last), 32'(want.last));
        end
      end
    end
  end

  // Ends the run if neither channel makes progress for too long.
  always @(posedge clk) begin : watchdog
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("flash_sector_ring_queue_control_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Fields a request ignores still get random values.
  task automatic queue_request(input mode_t m, input int ws, input int wo,
                               input int rs, input int ro, input bit drain);
    request_t r;
    r.mode       = m;
    r.wait_drain = drain;
    if (m == MODE_RESTORE) begin
      r.wsec = ws[RSECT_W-1:0];
      r.woff = wo[ROFFS_W-1:0];
      r.rsec = rs[RSECT_W-1:0];
      r.roff = ro[ROFFS_W-1:0];
    end else begin
      r.wsec = RSECT_W'($urandom);
      r.woff = ROFFS_W'($urandom);
      r.rsec = RSECT_W'($urandom);
      r.roff = ROFFS_W'($urandom);
    end
    requests_to_send.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input addr_t value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_AREA_BASE) begin
      area_base = value;
    end else begin
      index_addr = value;
    end
  endtask

  function automatic int pick_offset();
    case ($urandom_range(3))
      0:       return 0;
      1:       return SECTOR_BYTES - RECORD_BYTES * $urandom_range(1, 3);
      2:       return RECORD_BYTES * $urandom_range(SECTOR_BYTES / RECORD_BYTES - 1);
      default: return $urandom_range(SECTOR_BYTES - 1);
    endcase
  endfunction

  // Boundary cases: empty pop, catch-up, sector moves, overrun, bad restores.
  task automatic queue_directed();
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
    // Last slot of sector 0, then a move into sector 1.
    queue_request(MODE_RESTORE, 0, 4064, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b1);
    // Write wraps around the ring onto the read sector.
    queue_request(MODE_RESTORE, 15, 4064, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    // Read pointer crosses into the next sector.
    queue_request(MODE_RESTORE, 5, 0, 3, 4064, 1'b0);
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    // Read catches the write pointer right at a sector boundary.
    queue_request(MODE_RESTORE, 4, 0, 3, 4064, 1'b0);
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    // Negative offset difference: truncation toward zero, then clamp to zero.
    queue_request(MODE_RESTORE, 2, 16, 1, 40, 1'b0);
    queue_request(MODE_RESTORE, 2, 0, 2, 64, 1'b0);
    queue_request(MODE_POP, 0, 0, 0, 0, 1'b0);
    // Out-of-range restores.
    queue_request(MODE_RESTORE, 16, 0, 0, 0, 1'b0);
    queue_request(MODE_RESTORE, 255, 65535, 255, 65535, 1'b0);
    queue_request(MODE_RESTORE, 0, 4096, 0, 0, 1'b0);
    // Largest legal pointers, nearly full ring.
    queue_request(MODE_RESTORE, 15, 4095, 0, 0, 1'b0);
    queue_request(MODE_PUSH, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_RESTORE, 0, 0, 0, 0, 1'b0);
    queue_request(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
  endtask

  // Mostly push/pop bursts from a placed pointer pair, plus some noise.
  task automatic queue_random(input int count);
    int target;
    int kind;
    int burst;
    int push_pct;
    int ws;
    bit drain;
    target = requests_to_send.size() + count;
    while (requests_to_send.size() < target) begin
      kind  = $urandom_range(99);
      drain = ($urandom_range(19) == 0);
      if (kind < 70) begin
        if ($urandom_range(1) == 1) begin
          ws = $urandom_range(SECTOR_COUNT - 1);
          queue_request(MODE_RESTORE, ws, pick_offset(),
                        ($urandom_range(3) == 0) ? (ws + 1) % SECTOR_COUNT
                                                 : $urandom_range(SECTOR_COUNT - 1),
                        pick_offset(), drain);
          drain = 1'b0;
        end
        burst    = $urandom_range(4, 16);
        push_pct = $urandom_range(30, 80);
        repeat (burst) begin
          queue_request(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP,
                        0, 0, 0, 0, drain);
          drain = 1'b0;
        end
      end else if (kind < 82) begin
        queue_request(MODE_RESTORE, $urandom_range(255), $urandom_range(65535),
                      $urandom_range(255), $urandom_range(65535), drain);
      end else if (kind < 90) begin
        queue_request(MODE_CLEAR, 0, 0, 0, 0, drain);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_request(MODE_POP, 0, 0, 0, 0, drain);
          drain = 1'b0;
        end
      end
    end
  endtask

  // One phase: configure while idle, send, then wait for every result.
  task automatic run_phase(input addr_t base, input addr_t idx_addr, input int idle_pct,
                           input int stall_pct, input bit directed, input int count);
    write_reg(REG_AREA_BASE, base);
    write_reg(REG_INDEX_ADDR, idx_addr);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (directed) begin
      queue_directed();
    end
    queue_random(count);
    while (requests_to_send.size() != 0 || flash_ops_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_AREA_BASE;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_phase(24'hFFF000, 24'hFFFFFF, 0, 0, 1'b1, 90);
    run_phase(24'h000000, 24'h000000, 68, 0, 1'b0, 90);
    run_phase(addr_t'($urandom), addr_t'($urandom), 0, 68, 1'b0, 90);
    run_phase(24'hFFFFFF, addr_t'($urandom), 35, 35, 1'b0, 90);
    run_phase(AREA_BASE_RESET, INDEX_ADDR_RESET, 0, 0, 1'b0, 40);

    $display("Covered %0d pushes, %0d pops, %0d empty pops, %0d clears, %0d/%0d good/bad restores.",
             n_push, n_pop, n_empty_pop, n_clear, n_restore_ok, n_restore_bad);
    $display("Saw %0d sector moves, %0d read overruns, %0d catch-ups; %0d results, %0d mismatches.",
             n_sector_moves, n_overruns, n_caught_up, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("flash_sector_ring_queue_control_tb: PASS");
    end else begin
      $display("flash_sector_ring_queue_control_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== flash_sector_ring_queue_control.f =====
hdl/fsrq_pkg.sv
hdl/fsrq_if.sv
hdl/fsrq_ctrl.sv
hdl/fsrq_dp.sv
hdl/flash_sector_ring_queue_control.sv
hdl/fsrq_checker.sv
tb/flash_sector_ring_queue_control_tb.sv
